// ===== src/rfp_pkg.sv =====
// rfp_pkg: shared types and constants for the region file name parser
// no dependencies; used by region_filename_parser_top and its checker
`timescale 1ns / 1ps

package rfp_pkg;

    // coordinate accumulator width
    localparam int COORD_BITS = 32;
    localparam int OUT_BITS   = 32;

    // parse phases
    localparam logic [2:0] PH_R    = 3'd0;
    localparam logic [2:0] PH_DOT  = 3'd1;
    localparam logic [2:0] PH_X    = 3'd2;
    localparam logic [2:0] PH_Z    = 3'd3;
    localparam logic [2:0] PH_M    = 3'd4;
    localparam logic [2:0] PH_C    = 3'd5;
    localparam logic [2:0] PH_A    = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    // character codes
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // input request: one path byte
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } rfp_in_t;

    // result request: verdict and coordinates
    typedef struct packed {
        logic                       ok;
        logic signed [OUT_BITS-1:0] x_coord;
        logic signed [OUT_BITS-1:0] z_coord;
    } rfp_out_t;

endpackage

// ===== src/region_filename_parser_top.sv =====
// region_filename_parser_top: out_valid rises after the last byte is accepted.
// throughput one byte per cycle; a byte is held back only while a finished result
// waits in the output register and the next registered byte is also a last byte.
// the byte register feeds the phase/accumulator update and the result register.
// reset (rst_n low, async) empties both registers and returns the parser to "expect r".
// depends on rfp_pkg
`timescale 1ns / 1ps

module region_filename_parser_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rfp_pkg::rfp_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rfp_pkg::rfp_out_t out_data
);

    // input byte register
    logic                 s1_valid_reg;
    rfp_pkg::rfp_in_t     s1_data_reg;
    logic                 s1_adv;
    logic                 s1_fire;

    // parse state
    logic [2:0]                      phase_reg, phase_next;
    logic                            failed_reg, failed_next;
    logic                            x_neg_reg, x_neg_next;
    logic                            z_neg_reg, z_neg_next;
    logic [rfp_pkg::COORD_BITS-1:0]  x_acc_reg, x_acc_next;
    logic [rfp_pkg::COORD_BITS-1:0]  z_acc_reg, z_acc_next;
    logic                            seen_reg, seen_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    rfp_pkg::rfp_out_t    out_data_reg, out_data_next;

    // byte decode and shared body update
    logic [7:0]                      c;
    logic                            is_digit;
    logic [3:0]                      digit;
    logic                            cur_neg;
    logic [rfp_pkg::COORD_BITS-1:0]  cur_acc;
    logic [rfp_pkg::COORD_BITS-1:0]  acc_times_ten;
    logic signed [rfp_pkg::COORD_BITS-1:0] x_fin;
    logic signed [rfp_pkg::COORD_BITS-1:0] z_fin;
    logic                            good;

    // handshake: the byte stage only stalls on a last byte with the result slot busy
    assign s1_adv   = !s1_data_reg.last_char || !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign c        = s1_data_reg.char_code;
    assign is_digit = (c >= rfp_pkg::CH_ZERO) && (c <= rfp_pkg::CH_NINE);
    assign digit    = 4'(c - rfp_pkg::CH_ZERO);
    assign cur_neg  = (phase_reg == rfp_pkg::PH_X) ? x_neg_reg : z_neg_reg;
    assign cur_acc  = (phase_reg == rfp_pkg::PH_X) ? x_acc_reg : z_acc_reg;

    // acc * 10 + digit as two shifted adds
    assign acc_times_ten = rfp_pkg::COORD_BITS'((cur_acc << 3) + (cur_acc << 1)
                                                + rfp_pkg::COORD_BITS'(digit));

    // next parse state and result
    always_comb
    begin
        phase_next     = phase_reg;
        failed_next    = failed_reg;
        x_neg_next     = x_neg_reg;
        z_neg_next     = z_neg_reg;
        x_acc_next     = x_acc_reg;
        z_acc_next     = z_acc_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        good           = 1'b1;
        x_fin          = '0;
        z_fin          = '0;

        if (s1_fire)
        begin
            if (c == rfp_pkg::CH_SLASH || c == rfp_pkg::CH_BSLASH)
            begin
                phase_next  = rfp_pkg::PH_R;
                failed_next = 1'b0;
                x_neg_next  = 1'b0;
                z_neg_next  = 1'b0;
                x_acc_next  = '0;
                z_acc_next  = '0;
                seen_next   = 1'b0;
            end
            else if (!failed_reg)
            begin
                unique case (phase_reg)
                    rfp_pkg::PH_R:
                    begin
                        good = (c == rfp_pkg::CH_R);
                        if (good) phase_next = rfp_pkg::PH_DOT;
                    end
                    rfp_pkg::PH_DOT:
                    begin
                        good = (c == rfp_pkg::CH_DOT);
                        if (good) phase_next = rfp_pkg::PH_X;
                    end
                    rfp_pkg::PH_X, rfp_pkg::PH_Z:
                    begin
                        if (is_digit)
                        begin
                            seen_next = 1'b1;
                            if (phase_reg == rfp_pkg::PH_X) x_acc_next = acc_times_ten;
                            else                            z_acc_next = acc_times_ten;
                        end
                        else if (c == rfp_pkg::CH_MINUS && !seen_reg && !cur_neg)
                        begin
                            if (phase_reg == rfp_pkg::PH_X) x_neg_next = 1'b1;
                            else                            z_neg_next = 1'b1;
                        end
                        else if (c == rfp_pkg::CH_DOT && seen_reg)
                        begin
                            seen_next  = 1'b0;
                            phase_next = (phase_reg == rfp_pkg::PH_X) ? rfp_pkg::PH_Z
                                                                      : rfp_pkg::PH_M;
                        end
                        else
                        begin
                            good = 1'b0;
                        end
                    end
                    rfp_pkg::PH_M:
                    begin
                        good = (c == rfp_pkg::CH_M);
                        if (good) phase_next = rfp_pkg::PH_C;
                    end
                    rfp_pkg::PH_C:
                    begin
                        good = (c == rfp_pkg::CH_C);
                        if (good) phase_next = rfp_pkg::PH_A;
                    end
                    rfp_pkg::PH_A:
                    begin
                        good = (c == rfp_pkg::CH_A);
                        if (good) phase_next = rfp_pkg::PH_DONE;
                    end
                    default:
                    begin
                        good = 1'b0;
                    end
                endcase
                if (!good) failed_next = 1'b1;
            end

            // end of path: emit verdict and clear for the next path
            if (s1_data_reg.last_char)
            begin
                x_fin = x_neg_next ? -$signed(x_acc_next) : $signed(x_acc_next);
                z_fin = z_neg_next ? -$signed(z_acc_next) : $signed(z_acc_next);
                out_valid_next   = 1'b1;
                out_data_next.ok = !failed_next && (phase_next == rfp_pkg::PH_DONE);
                out_data_next.x_coord = out_data_next.ok ? rfp_pkg::OUT_BITS'(x_fin) : '0;
                out_data_next.z_coord = out_data_next.ok ? rfp_pkg::OUT_BITS'(z_fin) : '0;
                phase_next  = rfp_pkg::PH_R;
                failed_next = 1'b0;
                x_neg_next  = 1'b0;
                z_neg_next  = 1'b0;
                x_acc_next  = '0;
                z_acc_next  = '0;
                seen_next   = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= rfp_pkg::PH_R;
            failed_reg    <= 1'b0;
            x_neg_reg     <= 1'b0;
            z_neg_reg     <= 1'b0;
            x_acc_reg     <= '0;
            z_acc_reg     <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready) s1_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            x_neg_reg     <= x_neg_next;
            z_neg_reg     <= z_neg_next;
            x_acc_reg     <= x_acc_next;
            z_acc_reg     <= z_acc_next;
            seen_reg      <= seen_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) s1_data_reg <= in_data;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== src/rfp_checker.sv =====
// rfp_checker: port-level assertions for region_filename_parser_top, with its bind
// depends on rfp_pkg and region_filename_parser_top
`timescale 1ns / 1ps

module rfp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input rfp_pkg::rfp_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input rfp_pkg::rfp_out_t out_data
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // failed parse reports zero coordinates
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.x_coord == '0 && out_data.z_coord == '0)
        else $error("nonzero coordinates on failed parse");

    // input stalls only under output backpressure
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a new result follows an accepted last byte through the byte and result registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_char, 2))
        else $error("result without preceding last byte");

endmodule

bind region_filename_parser_top rfp_checker u_rfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
